// ===== design/rtsg_pkg.sv =====
// ----------------------------------------------------------------------------
// rtsg_pkg: shared definitions for the right-triangle span generator
// Widths, status and register codes, and the sideband word that travels
// alongside the pipelined divider.
// ----------------------------------------------------------------------------
package rtsg_pkg;

  // Coordinate width of the vertex, row and clip fields.
  localparam int CoordBits = 16;
  // One extra bit for differences of two coordinates.
  localparam int CoordExt  = CoordBits + 1;
  // Hypotenuse arithmetic keeps two guard bits over a coordinate.
  localparam int HypBits   = CoordBits + 2;
  // Buffer-relative outputs.
  localparam int OutBits   = CoordBits + 1;
  // Q8 progress, 0..256 inclusive.
  localparam int ProgBits  = 9;
  // Product of a coordinate difference and a zero-extended progress.
  localparam int ProdBits  = CoordExt + ProgBits + 1;
  localparam int ColorBits = 32;
  localparam int OpaBits   = 8;
  localparam int StatusBits = 3;
  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = CoordBits;

  // Fixed-point constants of the interpolation.
  localparam int ProgOne   = 256;
  localparam int RoundHalf = 128;
  // Bias that turns an arithmetic shift into truncation towards zero.
  localparam int TruncBias = 255;
  localparam int FracBits  = 8;

  // Reset values of the configuration registers.
  localparam logic [OpaBits-1:0]          FloorReset = OpaBits'(2);
  localparam logic signed [CoordBits-1:0] ClipHiReset = CoordBits'(32767);

  typedef enum logic [StatusBits-1:0] {
    StSpan        = 3'd0,
    StTransparent = 3'd1,
    StGradient    = 3'd2,
    StNotRight    = 3'd3,
    StRowOut      = 3'd4,
    StClipped     = 3'd5
  } status_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgOpacityFloor = 3'd0,
    CfgClipLeft     = 3'd1,
    CfgClipTop      = 3'd2,
    CfgClipRight    = 3'd3,
    CfgClipBottom   = 3'd4,
    CfgOriginX      = 3'd5,
    CfgOriginY      = 3'd6
  } cfg_idx_e;

  // Everything a word still needs once its progress has been divided out.
  typedef struct packed {
    status_e                      status;
    logic                         last_row;
    logic                         row_ok;
    logic signed [CoordBits-1:0]  row;
    logic signed [CoordBits-1:0]  cx;
    logic signed [CoordBits-1:0]  hx;
    logic signed [CoordExt-1:0]   diff;
    logic [ColorBits-1:0]         color;
  } side_t;

endpackage

// ===== design/rtsg_divider.sv =====
// ----------------------------------------------------------------------------
// rtsg_divider: pipelined restoring divider for the Q8 progress
// Computes floor(num * 256 / den) for num <= den, one quotient bit per
// stage, and carries a sideband word alongside each quotient.
// ----------------------------------------------------------------------------
module rtsg_divider (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic [rtsg_pkg::CoordBits-1:0]        num_i,
  input  logic [rtsg_pkg::CoordBits-1:0]        den_i,
  input  rtsg_pkg::side_t                       side_i,
  output logic                                  valid_o,
  output logic [rtsg_pkg::ProgBits-1:0]         quot_o,
  output rtsg_pkg::side_t                       side_o
);

  localparam int Cw = rtsg_pkg::CoordBits;
  localparam int Qw = rtsg_pkg::ProgBits;

  logic                vld_q  [Qw];
  logic [Cw-1:0]       rem_q  [Qw];
  logic [Cw-1:0]       den_q  [Qw];
  logic [Qw-1:0]       quot_q [Qw];
  rtsg_pkg::side_t     side_q [Qw];

  for (genvar k = 0; k < Qw; k++) begin : g_stage
    logic          vld_in;
    logic [Cw:0]   trial;
    logic [Cw-1:0] den_in;
    logic [Qw-1:0] quot_in;
    logic          take;
    rtsg_pkg::side_t side_in;

    // The first stage decides the integer bit, the others shift the
    // remainder left by one before the trial subtraction.
    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign trial   = {1'b0, num_i};
      assign den_in  = den_i;
      assign quot_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign trial   = {rem_q[k-1], 1'b0};
      assign den_in  = den_q[k-1];
      assign quot_in = quot_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign take = (trial >= {1'b0, den_in});

    // Valid bit of the stage.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    // Partial remainder, divisor and quotient so far.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? Cw'(trial - {1'b0, den_in}) : trial[Cw-1:0];
        den_q[k]  <= den_in;
        quot_q[k] <= {quot_in[Qw-2:0], take};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[Qw-1];
  assign quot_o  = quot_q[Qw-1];
  assign side_o  = side_q[Qw-1];

endmodule

// ===== design/right_triangle_span_generator.sv =====
// ----------------------------------------------------------------------------
// right_triangle_span_generator: scanline span of an axis-aligned right
// triangle, clipped to a rectangle and moved to buffer coordinates.
//
// Usage: an input word carries three vertices, the row wanted, an opacity,
// a gradient flag and a colour. It is taken at a clock edge where
// in_valid_i is high and in_stall_o is low. Exactly one result word leaves
// for each input word, in order, taken where out_valid_o is high and
// out_stall_i is low.
// From acceptance to out_valid_o a word passes two decode stages, nine
// divider stages (one progress bit each) and five stages of multiply,
// rounding, hypotenuse, clipping and the output register.
// Throughput is one word per cycle while no result is held. The whole
// pipeline advances as one; while a result waits under out_stall_i the
// pipeline holds and in_stall_o is raised, so nothing is lost or repeated.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at
// the next edge and must only be issued while the pipeline is empty.
// Reset empties the pipeline and loads the register defaults: opacity
// floor 2, clip rectangle 0..32767 on both axes, buffer origin 0.
// ----------------------------------------------------------------------------
module right_triangle_span_generator (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration port
  input  logic                                   cfg_we_i,
  input  logic [rtsg_pkg::CfgIdxBits-1:0]        cfg_idx_i,
  input  logic [rtsg_pkg::CfgDataBits-1:0]       cfg_data_i,
  // Input channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [rtsg_pkg::CoordBits-1:0]  vertex_a_x_i,
  input  logic signed [rtsg_pkg::CoordBits-1:0]  vertex_a_y_i,
  input  logic signed [rtsg_pkg::CoordBits-1:0]  vertex_b_x_i,
  input  logic signed [rtsg_pkg::CoordBits-1:0]  vertex_b_y_i,
  input  logic signed [rtsg_pkg::CoordBits-1:0]  vertex_c_x_i,
  input  logic signed [rtsg_pkg::CoordBits-1:0]  vertex_c_y_i,
  input  logic signed [rtsg_pkg::CoordBits-1:0]  row_i,
  input  logic [rtsg_pkg::OpaBits-1:0]           opacity_i,
  input  logic                                   gradient_on_i,
  input  logic [rtsg_pkg::ColorBits-1:0]         fill_color_i,
  // Output channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [rtsg_pkg::StatusBits-1:0]        status_o,
  output logic signed [rtsg_pkg::OutBits-1:0]    span_x_start_o,
  output logic signed [rtsg_pkg::OutBits-1:0]    span_x_end_o,
  output logic signed [rtsg_pkg::OutBits-1:0]    span_y_o,
  output logic [rtsg_pkg::ColorBits-1:0]         span_color_o,
  output logic                                   last_row_o
);

  localparam int Cw = rtsg_pkg::CoordBits;
  localparam int Ce = rtsg_pkg::CoordExt;
  localparam int Hw = rtsg_pkg::HypBits;
  localparam int Ow = rtsg_pkg::OutBits;
  localparam int Pw = rtsg_pkg::ProdBits;
  localparam int Qw = rtsg_pkg::ProgBits;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [rtsg_pkg::OpaBits-1:0] floor_q;
  logic signed [Cw-1:0]         clip_l_q, clip_t_q, clip_r_q, clip_b_q;
  logic signed [Cw-1:0]         org_x_q, org_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q  <= rtsg_pkg::FloorReset;
      clip_l_q <= '0;
      clip_t_q <= '0;
      clip_r_q <= rtsg_pkg::ClipHiReset;
      clip_b_q <= rtsg_pkg::ClipHiReset;
      org_x_q  <= '0;
      org_y_q  <= '0;
    end else if (cfg_we_i) begin
      case (rtsg_pkg::cfg_idx_e'(cfg_idx_i))
        rtsg_pkg::CfgOpacityFloor: floor_q  <= cfg_data_i[rtsg_pkg::OpaBits-1:0];
        rtsg_pkg::CfgClipLeft:     clip_l_q <= cfg_data_i;
        rtsg_pkg::CfgClipTop:      clip_t_q <= cfg_data_i;
        rtsg_pkg::CfgClipRight:    clip_r_q <= cfg_data_i;
        rtsg_pkg::CfgClipBottom:   clip_b_q <= cfg_data_i;
        rtsg_pkg::CfgOriginX:      org_x_q  <= cfg_data_i;
        rtsg_pkg::CfgOriginY:      org_y_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The pipeline moves as one unless the output word is held.
  logic adv;
  logic out_valid_q;
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // --------------------------------------------------------------------------
  // Stage 1: early status checks and right-angle corner search
  // --------------------------------------------------------------------------
  logic signed [Cw-1:0] px [3];
  logic signed [Cw-1:0] py [3];
  logic [2:0]           m_h, m_v;
  logic [1:0]           ci, hi, vi;
  logic                 found;
  rtsg_pkg::status_e    s1_status_d;

  assign px[0] = vertex_a_x_i;
  assign py[0] = vertex_a_y_i;
  assign px[1] = vertex_b_x_i;
  assign py[1] = vertex_b_y_i;
  assign px[2] = vertex_c_x_i;
  assign py[2] = vertex_c_y_i;

  always_comb begin
    int j;
    int k;
    m_h   = '0;
    m_v   = '0;
    ci    = '0;
    hi    = '0;
    vi    = '0;
    found = 1'b0;
    // A corner shares one coordinate with each of the other two vertices.
    for (int i = 0; i < 3; i++) begin
      j = (i == 2) ? 0 : i + 1;
      k = (i == 0) ? 2 : i - 1;
      m_h[i] = (py[i] == py[j]) && (px[i] == px[k]);
      m_v[i] = (px[i] == px[j]) && (py[i] == py[k]);
    end
    // First vertex in order a, b, c wins.
    for (int i = 0; i < 3; i++) begin
      j = (i == 2) ? 0 : i + 1;
      k = (i == 0) ? 2 : i - 1;
      if (!found) begin
        if (m_h[i]) begin
          found = 1'b1;
          ci    = 2'(i);
          hi    = 2'(j);
          vi    = 2'(k);
        end else if (m_v[i]) begin
          found = 1'b1;
          ci    = 2'(i);
          hi    = 2'(k);
          vi    = 2'(j);
        end
      end
    end

    if (opacity_i <= floor_q) begin
      s1_status_d = rtsg_pkg::StTransparent;
    end else if (gradient_on_i) begin
      s1_status_d = rtsg_pkg::StGradient;
    end else if (!found) begin
      s1_status_d = rtsg_pkg::StNotRight;
    end else begin
      s1_status_d = rtsg_pkg::StSpan;
    end
  end

  logic                            s1_valid_q;
  rtsg_pkg::status_e               s1_status_q;
  logic signed [Cw-1:0]            s1_cx_q, s1_cy_q, s1_hx_q, s1_vy_q, s1_row_q;
  logic [rtsg_pkg::ColorBits-1:0]  s1_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_status_q <= s1_status_d;
      s1_cx_q     <= px[ci];
      s1_cy_q     <= py[ci];
      s1_hx_q     <= px[hi];
      s1_vy_q     <= py[vi];
      s1_row_q    <= row_i;
      s1_color_q  <= fill_color_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: row range, leg lengths and clip row test
  // --------------------------------------------------------------------------
  logic signed [Cw-1:0] top, bot;
  logic signed [Ce-1:0] num_s, den_s;
  logic [Ce-1:0]        num_m, den_m;
  logic                 row_bad;
  rtsg_pkg::side_t      s2_side_d;

  always_comb begin
    top     = (s1_cy_q < s1_vy_q) ? s1_cy_q : s1_vy_q;
    bot     = (s1_cy_q < s1_vy_q) ? s1_vy_q : s1_cy_q;
    row_bad = (s1_cy_q == s1_vy_q) || (s1_row_q < top) || (s1_row_q > bot);
    num_s   = Ce'(s1_row_q) - Ce'(s1_cy_q);
    den_s   = Ce'(s1_vy_q) - Ce'(s1_cy_q);
    num_m   = num_s[Ce-1] ? Ce'(-num_s) : Ce'(num_s);
    den_m   = den_s[Ce-1] ? Ce'(-den_s) : Ce'(den_s);

    s2_side_d.status   = (s1_status_q == rtsg_pkg::StSpan && row_bad) ?
                         rtsg_pkg::StRowOut : s1_status_q;
    s2_side_d.last_row = (s2_side_d.status == rtsg_pkg::StSpan) && (s1_row_q == bot);
    s2_side_d.row_ok   = (s1_row_q >= clip_t_q) && (s1_row_q <= clip_b_q);
    s2_side_d.row      = s1_row_q;
    s2_side_d.cx       = s1_cx_q;
    s2_side_d.hx       = s1_hx_q;
    s2_side_d.diff     = Ce'(s1_cx_q) - Ce'(s1_hx_q);
    s2_side_d.color    = s1_color_q;
  end

  logic            s2_valid_q;
  logic [Cw-1:0]   s2_num_q, s2_den_q;
  rtsg_pkg::side_t s2_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_num_q  <= num_m[Cw-1:0];
      s2_den_q  <= den_m[Cw-1:0];
      s2_side_q <= s2_side_d;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: Q8 progress along the vertical leg
  // --------------------------------------------------------------------------
  logic            dv_valid;
  logic [Qw-1:0]   dv_quot;
  rtsg_pkg::side_t dv_side;

  rtsg_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s2_valid_q),
    .num_i   (s2_num_q),
    .den_i   (s2_den_q),
    .side_i  (s2_side_q),
    .valid_o (dv_valid),
    .quot_o  (dv_quot),
    .side_o  (dv_side)
  );

  // --------------------------------------------------------------------------
  // Multiply stage: leg difference times clamped progress
  // --------------------------------------------------------------------------
  logic [Qw-1:0]        prog;
  logic signed [Pw-1:0] prod_d;

  assign prog   = (dv_quot > Qw'(rtsg_pkg::ProgOne)) ? Qw'(rtsg_pkg::ProgOne) : dv_quot;
  assign prod_d = dv_side.diff * $signed({1'b0, prog});

  logic                 mu_valid_q;
  logic signed [Pw-1:0] mu_prod_q;
  rtsg_pkg::side_t      mu_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_valid_q <= 1'b0;
    end else if (adv) begin
      mu_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mu_prod_q <= prod_d;
      mu_side_q <= dv_side;
    end
  end

  // --------------------------------------------------------------------------
  // Rounding stage: add one half, divide by 256 truncating towards zero
  // --------------------------------------------------------------------------
  logic signed [Pw:0]   rnd_pos, rnd_neg;
  logic signed [Pw:0]   rnd_sh;

  always_comb begin
    rnd_pos = (Pw + 1)'(mu_prod_q) + (Pw + 1)'(rtsg_pkg::RoundHalf);
    rnd_neg = (Pw + 1)'(mu_prod_q) +
              (Pw + 1)'(rtsg_pkg::RoundHalf + rtsg_pkg::TruncBias);
    rnd_sh  = rnd_pos[Pw] ? (rnd_neg >>> rtsg_pkg::FracBits)
                          : (rnd_pos >>> rtsg_pkg::FracBits);
  end

  logic                 rd_valid_q;
  logic signed [Hw-1:0] rd_ofs_q;
  rtsg_pkg::side_t      rd_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (adv) begin
      rd_valid_q <= mu_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_ofs_q  <= rnd_sh[Hw-1:0];
      rd_side_q <= mu_side_q;
    end
  end

  // --------------------------------------------------------------------------
  // Hypotenuse stage: span ends ordered left to right
  // --------------------------------------------------------------------------
  logic signed [Hw-1:0] hyp, cx_w;

  assign hyp  = Hw'(rd_side_q.hx) + rd_ofs_q;
  assign cx_w = Hw'(rd_side_q.cx);

  logic                 hy_valid_q;
  logic signed [Hw-1:0] hy_x1_q, hy_x2_q;
  rtsg_pkg::side_t      hy_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hy_valid_q <= 1'b0;
    end else if (adv) begin
      hy_valid_q <= rd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hy_x1_q   <= (cx_w < hyp) ? cx_w : hyp;
      hy_x2_q   <= (cx_w < hyp) ? hyp : cx_w;
      hy_side_q <= rd_side_q;
    end
  end

  // --------------------------------------------------------------------------
  // Clip stage: trim the span to the clip rectangle columns
  // --------------------------------------------------------------------------
  logic signed [Hw-1:0] cl_w, cr_w;

  assign cl_w = Hw'(clip_l_q);
  assign cr_w = Hw'(clip_r_q);

  logic                 cp_valid_q;
  logic signed [Hw-1:0] cp_lx_q, cp_rx_q;
  rtsg_pkg::side_t      cp_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_valid_q <= 1'b0;
    end else if (adv) begin
      cp_valid_q <= hy_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cp_lx_q   <= (hy_x1_q > cl_w) ? hy_x1_q : cl_w;
      cp_rx_q   <= (hy_x2_q < cr_w) ? hy_x2_q : cr_w;
      cp_side_q <= hy_side_q;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: final status and buffer-relative span
  // --------------------------------------------------------------------------
  rtsg_pkg::status_e              fin_status;
  logic signed [Ow-1:0]           xs_d, xe_d, ys_d;
  logic [rtsg_pkg::ColorBits-1:0] col_d;
  logic                           last_d;

  always_comb begin
    fin_status = cp_side_q.status;
    if (fin_status == rtsg_pkg::StSpan && ((cp_lx_q > cp_rx_q) || !cp_side_q.row_ok)) begin
      fin_status = rtsg_pkg::StClipped;
    end
    last_d = cp_side_q.last_row;
    if (fin_status == rtsg_pkg::StSpan) begin
      xs_d  = Ow'(cp_lx_q - Hw'(org_x_q));
      xe_d  = Ow'(cp_rx_q - Hw'(org_x_q));
      ys_d  = Ow'(cp_side_q.row) - Ow'(org_y_q);
      col_d = cp_side_q.color;
    end else begin
      xs_d  = '0;
      xe_d  = '0;
      ys_d  = '0;
      col_d = '0;
    end
  end

  rtsg_pkg::status_e              out_status_q;
  logic signed [Ow-1:0]           out_xs_q, out_xe_q, out_y_q;
  logic [rtsg_pkg::ColorBits-1:0] out_col_q;
  logic                           out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= cp_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_status_q <= fin_status;
      out_xs_q     <= xs_d;
      out_xe_q     <= xe_d;
      out_y_q      <= ys_d;
      out_col_q    <= col_d;
      out_last_q   <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign span_x_start_o = out_xs_q;
  assign span_x_end_o   = out_xe_q;
  assign span_y_o       = out_y_q;
  assign span_color_o   = out_col_q;
  assign last_row_o     = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A span that survives clipping never runs right to left.
  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == rtsg_pkg::StSpan |-> span_x_start_o <= span_x_end_o)
    else $error("span start lies right of span end");

  // Words that draw nothing carry no span and no colour.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != rtsg_pkg::StSpan |->
      span_x_start_o == '0 && span_x_end_o == '0 && span_y_o == '0 && span_color_o == '0)
    else $error("non-span word carries span fields");

  // The bottom-row flag only comes with a span or a clipped span.
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_row_o |->
      status_o == rtsg_pkg::StSpan || status_o == rtsg_pkg::StClipped)
    else $error("last row flagged on a rejected word");

  // A held result stays valid and unchanged while it blocks the pipeline.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(span_y_o))
    else $error("held result changed under stall");

endmodule

// ===== tb/rtsg_span_checker.sv =====
// ----------------------------------------------------------------------------
// rtsg_span_checker: span predictor and scoreboard for the triangle block
// Follows the register port, predicts the span of every accepted input word
// and compares every accepted result word, field by field, with the oldest
// prediction still waiting. It reports the number of mismatches.
// ----------------------------------------------------------------------------
module rtsg_span_checker
  import rtsg_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Register port, as driven into the block
  input  logic                         cfg_we_i,
  input  logic [CfgIdxBits-1:0]        cfg_idx_i,
  input  logic [CfgDataBits-1:0]       cfg_data_i,
  // Input channel
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic signed [CoordBits-1:0]  vertex_a_x_i,
  input  logic signed [CoordBits-1:0]  vertex_a_y_i,
  input  logic signed [CoordBits-1:0]  vertex_b_x_i,
  input  logic signed [CoordBits-1:0]  vertex_b_y_i,
  input  logic signed [CoordBits-1:0]  vertex_c_x_i,
  input  logic signed [CoordBits-1:0]  vertex_c_y_i,
  input  logic signed [CoordBits-1:0]  row_i,
  input  logic [OpaBits-1:0]           opacity_i,
  input  logic                         gradient_on_i,
  input  logic [ColorBits-1:0]         fill_color_i,
  // Output channel
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [StatusBits-1:0]        status_i,
  input  logic signed [OutBits-1:0]    span_x_start_i,
  input  logic signed [OutBits-1:0]    span_x_end_i,
  input  logic signed [OutBits-1:0]    span_y_i,
  input  logic [ColorBits-1:0]         span_color_i,
  input  logic                         last_row_i,
  // Scoreboard state for the stimulus side
  output int                           pending_o,
  output int                           fail_count_o,
  output int                           spans_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Q8 fixed-point one and its rounding half.
  localparam longint Q8One  = 256;
  localparam longint Q8Half = 128;

  typedef struct packed {
    logic signed [CoordBits-1:0] ax, ay, bx, by, cx, cy, row;
    logic [OpaBits-1:0]          opacity;
    logic                        gradient;
    logic [ColorBits-1:0]        color;
  } tri_req_t;

  typedef struct packed {
    status_e                   status;
    logic signed [OutBits-1:0] x_start;
    logic signed [OutBits-1:0] x_end;
    logic signed [OutBits-1:0] y;
    logic [ColorBits-1:0]      color;
    logic                      last_row;
  } span_word_t;

  // Our own copy of the register file.
  logic [OpaBits-1:0]          opa_floor = FloorReset;
  logic signed [CoordBits-1:0] clip_l = '0;
  logic signed [CoordBits-1:0] clip_t = '0;
  logic signed [CoordBits-1:0] clip_r = ClipHiReset;
  logic signed [CoordBits-1:0] clip_b = ClipHiReset;
  logic signed [CoordBits-1:0] org_x = '0;
  logic signed [CoordBits-1:0] org_y = '0;

  span_word_t spans_due[$];
  span_word_t want;
  int         fails = 0;
  int         spans = 0;

  // Span of one word under the current registers.
  function automatic span_word_t predict_span(tri_req_t req);
    longint     px[3];
    longint     py[3];
    longint     row_v, top_y, bot_y, prog, hyp, x1, x2, lx, rx;
    int         ci, hi, vi, j, k;
    span_word_t res;
    res = '0;
    px[0] = req.ax; py[0] = req.ay;
    px[1] = req.bx; py[1] = req.by;
    px[2] = req.cx; py[2] = req.cy;
    row_v = req.row;
    if (req.opacity <= opa_floor) begin
      res.status = StTransparent;
      return res;
    end
    if (req.gradient) begin
      res.status = StGradient;
      return res;
    end
    // Look for the right-angle corner; the first vertex that qualifies wins.
    ci = -1;
    hi = 0;
    vi = 0;
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      if (ci < 0) begin
        if (py[i] == py[j] && px[i] == px[k]) begin
          ci = i; hi = j; vi = k;
        end else if (px[i] == px[j] && py[i] == py[k]) begin
          ci = i; hi = k; vi = j;
        end
      end
    end
    if (ci < 0) begin
      res.status = StNotRight;
      return res;
    end
    top_y = (py[ci] < py[vi]) ? py[ci] : py[vi];
    bot_y = (py[ci] > py[vi]) ? py[ci] : py[vi];
    if (bot_y == top_y || row_v < top_y || row_v > bot_y) begin
      res.status = StRowOut;
      return res;
    end
    // Q8 progress away from the corner row, then the hypotenuse x.
    prog = ((row_v - py[ci]) * Q8One) / (py[vi] - py[ci]);
    if (prog < 0) prog = -prog;
    if (prog > Q8One) prog = Q8One;
    hyp = px[hi] + ((px[ci] - px[hi]) * prog + Q8Half) / Q8One;
    x1 = (px[ci] < hyp) ? px[ci] : hyp;
    x2 = (px[ci] > hyp) ? px[ci] : hyp;
    res.last_row = (row_v == bot_y);
    // Clip, then move to buffer coordinates.
    lx = (x1 > clip_l) ? x1 : longint'(clip_l);
    rx = (x2 < clip_r) ? x2 : longint'(clip_r);
    if (lx > rx || row_v < clip_t || row_v > clip_b) begin
      res.status = StClipped;
      return res;
    end
    res.status  = StSpan;
    res.x_start = OutBits'(lx - org_x);
    res.x_end   = OutBits'(rx - org_x);
    res.y       = OutBits'(row_v - org_y);
    res.color   = req.color;
    return res;
  endfunction

  function automatic void match_field(string field, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", field, exp_v, got_v);
      fails++;
    end
  endfunction

  // Results are checked before new words are predicted, so a result can
  // never be matched against a word accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spans_due.delete();
      opa_floor    = FloorReset;
      clip_l       = '0;
      clip_t       = '0;
      clip_r       = ClipHiReset;
      clip_b       = ClipHiReset;
      org_x        = '0;
      org_y        = '0;
      pending_o    <= 0;
      fail_count_o <= fails;
      spans_o      <= spans;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (spans_due.size() == 0) begin
          $error("result word arrived with no span expected");
          fails++;
        end else begin
          want = spans_due.pop_front();
          match_field("status", longint'(want.status), longint'(status_i));
          match_field("span_x_start", longint'(want.x_start), longint'(span_x_start_i));
          match_field("span_x_end", longint'(want.x_end), longint'(span_x_end_i));
          match_field("span_y", longint'(want.y), longint'(span_y_i));
          match_field("span_color", longint'(want.color), longint'(span_color_i));
          match_field("last_row", longint'(want.last_row), longint'(last_row_i));
        end
        if (status_i == StSpan) spans++;
      end
      if (in_valid_i && !in_stall_i) begin
        spans_due.push_back(predict_span('{vertex_a_x_i, vertex_a_y_i, vertex_b_x_i,
                                           vertex_b_y_i, vertex_c_x_i, vertex_c_y_i,
                                           row_i, opacity_i, gradient_on_i,
                                           fill_color_i}));
      end
      // Register writes land at this edge and apply to later words.
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgOpacityFloor: opa_floor = cfg_data_i[OpaBits-1:0];
          CfgClipLeft:     clip_l = cfg_data_i;
          CfgClipTop:      clip_t = cfg_data_i;
          CfgClipRight:    clip_r = cfg_data_i;
          CfgClipBottom:   clip_b = cfg_data_i;
          CfgOriginX:      org_x = cfg_data_i;
          CfgOriginY:      org_y = cfg_data_i;
          default: ;
        endcase
      end
      pending_o    <= spans_due.size();
      fail_count_o <= fails;
      spans_o      <= spans;
    end
  end

endmodule

// ===== tb/tb_right_triangle_span_generator.sv =====
// ----------------------------------------------------------------------------
// tb_right_triangle_span_generator: stimulus and verdict for the span block
// Sends a directed set of triangles, then phases of random triangles under
// several register settings, with random gaps on the input and random stalls
// on the output. A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_right_triangle_span_generator;
  timeunit 1ns;
  timeprecision 1ps;
  import rtsg_pkg::*;

  typedef struct {
    logic signed [CoordBits-1:0] ax, ay, bx, by, cx, cy, row;
    logic [OpaBits-1:0]          opacity;
    logic                        gradient;
    logic [ColorBits-1:0]        color;
  } tri_req_t;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [CfgIdxBits-1:0]       cfg_idx;
  logic [CfgDataBits-1:0]      cfg_data;
  logic                        in_valid;
  logic                        in_stall;
  logic signed [CoordBits-1:0] vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y;
  logic signed [CoordBits-1:0] vertex_c_x, vertex_c_y, row;
  logic [OpaBits-1:0]          opacity;
  logic                        gradient_on;
  logic [ColorBits-1:0]        fill_color;
  logic                        out_valid;
  logic                        out_stall;
  logic [StatusBits-1:0]       status;
  logic signed [OutBits-1:0]   span_x_start, span_x_end, span_y;
  logic [ColorBits-1:0]        span_color;
  logic                        last_row;
  int                          pending, fail_count, spans;

  // Stimulus bookkeeping.
  logic [OpaBits-1:0] cur_floor = FloorReset;
  bit                 calm = 1'b0;
  int                 words_sent = 0;
  int                 settings = 1;

  right_triangle_span_generator DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .vertex_a_x_i   (vertex_a_x),
    .vertex_a_y_i   (vertex_a_y),
    .vertex_b_x_i   (vertex_b_x),
    .vertex_b_y_i   (vertex_b_y),
    .vertex_c_x_i   (vertex_c_x),
    .vertex_c_y_i   (vertex_c_y),
    .row_i          (row),
    .opacity_i      (opacity),
    .gradient_on_i  (gradient_on),
    .fill_color_i   (fill_color),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .span_x_start_o (span_x_start),
    .span_x_end_o   (span_x_end),
    .span_y_o       (span_y),
    .span_color_o   (span_color),
    .last_row_o     (last_row)
  );

  rtsg_span_checker span_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .vertex_a_x_i   (vertex_a_x),
    .vertex_a_y_i   (vertex_a_y),
    .vertex_b_x_i   (vertex_b_x),
    .vertex_b_y_i   (vertex_b_y),
    .vertex_c_x_i   (vertex_c_x),
    .vertex_c_y_i   (vertex_c_y),
    .row_i          (row),
    .opacity_i      (opacity),
    .gradient_on_i  (gradient_on),
    .fill_color_i   (fill_color),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .status_i       (status),
    .span_x_start_i (span_x_start),
    .span_x_end_i   (span_x_end),
    .span_y_i       (span_y),
    .span_color_i   (span_color),
    .last_row_i     (last_row),
    .pending_o      (pending),
    .fail_count_o   (fail_count),
    .spans_o        (spans)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall time limit.
  initial begin
    #8_000_000;
    $display("tb_right_triangle_span_generator: errors");
    $finish;
  end

  // Output stalls: mostly short, a few long, with long free stretches.
  initial begin : receiver_stall
    int unsigned free_run, hold;
    out_stall <= 1'b0;
    forever begin
      free_run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 8);
      repeat (free_run) @(posedge clk);
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      out_stall <= 1'b1;
      repeat (hold) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  function automatic tri_req_t tri_of(int ax, int ay, int bx, int by, int cx, int cy,
                                      int row_v, int opa, bit grad, logic [31:0] color);
    tri_req_t w;
    w.ax = CoordBits'(ax); w.ay = CoordBits'(ay);
    w.bx = CoordBits'(bx); w.by = CoordBits'(by);
    w.cx = CoordBits'(cx); w.cy = CoordBits'(cy);
    w.row      = CoordBits'(row_v);
    w.opacity  = OpaBits'(opa);
    w.gradient = grad;
    w.color    = color;
    return w;
  endfunction

  // Mostly well-formed right triangles in every vertex order, some broken
  // ones and some words of pure noise.
  function automatic tri_req_t random_triangle();
    tri_req_t                    w;
    int                          pick, mode, reach, cx, cy, hx, vy, row_lo, row_hi, slot;
    bit                          flip;
    logic signed [CoordBits-1:0] c_x, c_y, h_x, v_y;
    logic signed [CoordBits-1:0] xs[3];
    logic signed [CoordBits-1:0] ys[3];
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      w.ax = $urandom; w.ay = $urandom; w.bx = $urandom; w.by = $urandom;
      w.cx = $urandom; w.cy = $urandom; w.row = $urandom;
      w.opacity = $urandom; w.gradient = $urandom; w.color = $urandom;
      return w;
    end
    reach = ($urandom_range(0, 9) < 6) ? 255 : (($urandom_range(0, 3) != 0) ? 4000 : 65535);
    mode = $urandom_range(0, 9);
    if (mode < 5) begin
      cx = int'($urandom_range(0, 600)) - 300;
      cy = int'($urandom_range(0, 600)) - 300;
    end else if (mode < 9) begin
      cx = int'($urandom_range(0, 65535)) - 32768;
      cy = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      cx = $urandom_range(0, 1) ? -32768 : 32767;
      cy = $urandom_range(0, 1) ? -32768 : 32767;
    end
    hx = cx + int'($urandom_range(0, 2 * reach)) - reach;
    vy = cy + int'($urandom_range(0, 2 * reach)) - reach;
    if ($urandom_range(0, 19) == 0) hx = cx;
    if ($urandom_range(0, 19) == 0) vy = cy;
    c_x = CoordBits'(cx); c_y = CoordBits'(cy);
    h_x = CoordBits'(hx); v_y = CoordBits'(vy);
    row_lo = (c_y < v_y) ? int'(c_y) : int'(v_y);
    row_hi = (c_y > v_y) ? int'(c_y) : int'(v_y);
    case ($urandom_range(0, 9))
      0:       w.row = CoordBits'(row_lo);
      1:       w.row = CoordBits'(row_hi);
      8:       w.row = CoordBits'(row_lo - 1 - int'($urandom_range(0, 20)));
      9:       w.row = CoordBits'(row_hi + 1 + int'($urandom_range(0, 20)));
      default: w.row = CoordBits'(row_lo + int'($urandom_range(0, row_hi - row_lo)));
    endcase
    // Place the corner, then its horizontal and vertical partners.
    slot = $urandom_range(0, 2);
    flip = $urandom_range(0, 1);
    xs[slot] = c_x;
    ys[slot] = c_y;
    xs[(slot + (flip ? 2 : 1)) % 3] = h_x;
    ys[(slot + (flip ? 2 : 1)) % 3] = c_y;
    xs[(slot + (flip ? 1 : 2)) % 3] = c_x;
    ys[(slot + (flip ? 1 : 2)) % 3] = v_y;
    if (pick < 18) begin
      if ($urandom_range(0, 1)) xs[$urandom_range(0, 2)] += 1;
      else ys[$urandom_range(0, 2)] -= 1;
    end
    w.ax = xs[0]; w.ay = ys[0];
    w.bx = xs[1]; w.by = ys[1];
    w.cx = xs[2]; w.cy = ys[2];
    if (cur_floor < 8'd255 && $urandom_range(0, 9) != 0)
      w.opacity = OpaBits'($urandom_range(int'(cur_floor) + 1, 255));
    else
      w.opacity = $urandom;
    w.gradient = ($urandom_range(0, 19) == 0);
    w.color    = $urandom;
    return w;
  endfunction

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic drive_word(tri_req_t w);
    vertex_a_x <= w.ax; vertex_a_y <= w.ay;
    vertex_b_x <= w.bx; vertex_b_y <= w.by;
    vertex_c_x <= w.cx; vertex_c_y <= w.cy;
    row         <= w.row;
    opacity     <= w.opacity;
    gradient_on <= w.gradient;
    fill_color  <= w.color;
  endtask

  // Offer one word, hold it until taken, then idle for a random gap.
  task automatic offer(tri_req_t w);
    int g;
    drive_word(w);
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    words_sent++;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic run_random(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      offer(random_triangle());
    end
  endtask

  // Wait until every predicted span has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataBits-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic set_registers(logic [CfgDataBits-1:0] floor_word,
                               logic signed [CoordBits-1:0] left, top, right, bottom,
                               logic signed [CoordBits-1:0] origin_x, origin_y);
    wait_idle();
    write_reg(CfgOpacityFloor, floor_word);
    write_reg(CfgClipLeft, left);
    write_reg(CfgClipTop, top);
    write_reg(CfgClipRight, right);
    write_reg(CfgClipBottom, bottom);
    write_reg(CfgOriginX, origin_x);
    write_reg(CfgOriginY, origin_y);
    cfg_we <= 1'b0;
    cur_floor = floor_word[OpaBits-1:0];
    settings++;
  endtask

  initial begin
    int lo_x, hi_x, lo_y, hi_y;
    rst_n    <= 1'b0;
    cfg_we   <= 1'b0;
    cfg_idx  <= CfgOpacityFloor;
    cfg_data <= '0;
    in_valid <= 1'b0;
    drive_word(tri_of(0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 32'h0));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset registers.
    offer(tri_of(10, 10, 50, 10, 10, 90, 40, 2, 1'b0, 32'h1234_5678));  // opacity at floor
    offer(tri_of(10, 10, 50, 10, 10, 90, 40, 0, 1'b0, 32'h1234_5678));
    offer(tri_of(10, 10, 50, 10, 10, 90, 40, 3, 1'b0, 32'h1234_5678));  // just above floor
    offer(tri_of(10, 10, 50, 10, 10, 90, 40, 255, 1'b1, 32'hCAFE_0001)); // gradient
    offer(tri_of(0, 0, 10, 5, 20, 30, 10, 200, 1'b0, 32'h0));           // not right
    offer(tri_of(10, 10, 50, 10, 10, 10, 10, 200, 1'b0, 32'h0));         // flat
    offer(tri_of(10, 10, 50, 10, 10, 90, 5, 200, 1'b0, 32'h0));          // row above
    offer(tri_of(10, 10, 50, 10, 10, 90, 91, 200, 1'b0, 32'h0));         // row below
    offer(tri_of(10, 10, 50, 10, 10, 90, 10, 200, 1'b0, 32'hA5A5_A5A5)); // corner row
    offer(tri_of(10, 10, 50, 10, 10, 90, 90, 200, 1'b0, 32'h5A5A_5A5A)); // apex row
    // Corner at each vertex, at b and c in both orientations.
    offer(tri_of(20, 80, 20, 20, 70, 20, 50, 99, 1'b0, 32'h0000_00FF));
    offer(tri_of(100, 40, 60, 0, 60, 40, 30, 99, 1'b0, 32'h0000_FF00));
    offer(tri_of(30, 30, 30, 100, 0, 30, 60, 99, 1'b0, 32'h00FF_0000));
    offer(tri_of(200, 5, 120, 5, 120, 70, 5, 99, 1'b0, 32'hFF00_0000));
    offer(tri_of(7, 300, 90, 200, 7, 200, 250, 99, 1'b0, 32'h8000_0001));
    // Clipped in x, and clipped in y on the last row.
    offer(tri_of(-100, 50, -20, 50, -100, 150, 100, 99, 1'b0, 32'h1));
    offer(tri_of(10, -50, 60, -50, 10, -5, -5, 99, 1'b0, 32'h2));
    // Extreme coordinates.
    offer(tri_of(-32768, -32768, 32767, -32768, -32768, 32767, 0, 255, 1'b0, 32'hFFFF_FFFF));
    offer(tri_of(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 255, 1'b0, 32'h0));
    offer(tri_of(32767, 32767, 0, 32767, 32767, 0, 32767, 255, 1'b0, 32'h7FFF_FFFF));
    // Vertical leg running upwards from the corner.
    offer(tri_of(1000, 2000, 500, 2000, 1000, 1000, 1500, 255, 1'b0, 32'hFFFF_FFFF));
    // All three vertices on one point.
    offer(tri_of(7, 7, 7, 7, 7, 7, 7, 128, 1'b0, 32'h0));
    offer(tri_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 255, 1'b0, 32'h0));

    // Widest clip rectangle, lowest floor, origin at the negative corner.
    set_registers(16'h0000, -32768, -32768, 32767, 32767, -32768, -32768);
    run_random(380);
    // Small window around the screen origin.
    set_registers(16'h0080, -200, -150, 200, 150, -100, 50);
    run_random(350);
    // Highest floor, written with junk in the upper data bits.
    set_registers(16'hA5FF, -300, -300, 300, 300, 0, 0);
    run_random(40);
    // Empty clip rectangle and extreme origins.
    set_registers(16'h5A00, 32767, -32768, -32768, 32767, -32768, 32767);
    run_random(60);
    // Random ordered window and origin.
    lo_x = -int'($urandom_range(0, 2000));
    hi_x = $urandom_range(0, 2000);
    lo_y = -int'($urandom_range(0, 2000));
    hi_y = $urandom_range(0, 2000);
    set_registers($urandom_range(0, 254), lo_x, lo_y, hi_x, hi_y, $urandom, $urandom);
    run_random(250);
    // Reset-like window with the origin at the opposite extremes.
    set_registers(16'h0002, 0, 0, 32767, 32767, 32767, -32768);
    run_random(250);

    // Drain, then allow the pipeline time to show any stray word.
    wait_idle();
    repeat (24) @(posedge clk);
    $display("Sent %0d triangle words under %0d register settings; %0d came back as spans.",
             words_sent, settings, spans);
    if (fail_count == 0) begin
      $display("tb_right_triangle_span_generator: clean");
    end else begin
      $display("tb_right_triangle_span_generator: errors");
    end
    $finish;
  end

endmodule
